### hw/rtl/udp_header_classify_steer_assert.svh
// Assertion macros shared by the UDP header classifier RTL.
`ifndef UDP_HEADER_CLASSIFY_STEER_ASSERT_SVH
`define UDP_HEADER_CLASSIFY_STEER_ASSERT_SVH

`ifndef SYNTHESIS

`define UHCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udp_header_classify_steer: same-cycle check failed");

`define UHCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udp_header_classify_steer: next-cycle check failed");

`else

`define UHCS_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define UHCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/udp_hcs_pkg.sv
// Types, constants and codes shared by the UDP header classifier modules.
`timescale 1ns / 1ps
`default_nettype none

package udp_hcs_pkg;

  // Block parameters.
  localparam logic [6:0] MAX_CPU          = 7'd64;
  localparam logic [7:0] APP_HEADER_BYTES = 8'd20;

  // Header layout and match values.
  localparam logic [7:0]  ETH_LEN          = 8'd14;
  localparam logic [7:0]  IPV4_MIN_END     = 8'd34;
  localparam logic [6:0]  ETH_TYPE_OFF_HI  = 7'd12;
  localparam logic [6:0]  ETH_TYPE_OFF_LO  = 7'd13;
  localparam logic [6:0]  IP_IHL_OFF       = 7'd14;
  localparam logic [6:0]  IP_PROTO_OFF     = 7'd23;
  localparam logic [7:0]  UDP_DPORT_OFF    = 8'd2;
  localparam logic [7:0]  UDP_HDR_LEN      = 8'd8;
  localparam logic [7:0]  APP_MAGIC_OFF    = 8'd8;
  localparam logic [7:0]  APP_KEY_OFF      = 8'd12;
  localparam logic [7:0]  APP_KEY_END      = 8'd16;
  localparam logic [3:0]  MIN_IHL          = 4'd5;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
  localparam logic [15:0] DEFAULT_UDP_PORT = 16'd9999;
  localparam logic [31:0] APP_MAGIC        = 32'h4C414D49;
  localparam logic [6:0]  OFFSET_MAX       = 7'd127;

  // Remainder unit: six remainder bits followed by one key byte.
  localparam int DIV_W     = 14;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int OUT_W = 48;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UDP_PORT  = 2'd0;
  localparam logic [1:0] CFG_CPU_COUNT = 2'd1;
  localparam logic [1:0] CFG_CPU_MASK  = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_REDIRECT = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_DROPPED  = 3'd1,
    CLS_PASSED   = 3'd2,
    CLS_REDIRECT = 3'd3,
    CLS_INVALID  = 3'd4
  } stat_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY_DIV,
    ST_END_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_from_byte;
    logic key_load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_byte;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/udp_hcs_div.sv
// Iterative remainder unit: one dividend bit per cycle, restoring subtract.
`timescale 1ns / 1ps
`default_nettype none

module udp_hcs_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [udp_hcs_pkg::DIV_W-1:0]   dividend,
  input  wire logic [6:0]                      divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [5:0]                           remainder
);
  import udp_hcs_pkg::*;

  logic [DIV_W-1:0]     shreg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [6:0]           trial;
  logic [5:0]           rem_step;

  // The remainder stays below the divisor, so the trial value fits seven bits.
  always_comb begin
    trial = {remainder, shreg[DIV_W-1]};
    if (trial >= divisor) begin
      rem_step = 6'(trial - divisor);
    end else begin
      rem_step = trial[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= {shreg[DIV_W-2:0], 1'b0};
      remainder <= rem_step;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/udp_hcs_datapath.sv
// Datapath: configuration, header field capture, classification and counters.
`timescale 1ns / 1ps
`default_nettype none

module udp_hcs_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire udp_hcs_pkg::ctrl_cmd_t           cmd,
  output udp_hcs_pkg::dp_status_t               status,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             cfg_valid,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [63:0]                      cfg_data,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [udp_hcs_pkg::OUT_W-1:0]         out_data
);
  import udp_hcs_pkg::*;

  logic [15:0] udp_port;
  logic [7:0]  cpu_count;
  logic [63:0] cpu_present_mask;

  logic [6:0]  byte_offset;
  logic [15:0] ether_type;
  logic [3:0]  ip_words;
  logic [7:0]  ip_protocol;
  logic [15:0] dest_port;
  logic [31:0] magic_word;
  logic [5:0]  key_remainder;
  logic [31:0] stat_cnt [4];

  logic [6:0]       cpu_n;
  logic [7:0]       off8;
  logic [7:0]       udp_start;
  logic             ihl_ok;
  logic             in_dport;
  logic             in_magic;
  logic [5:0]       key_cur;
  logic [DIV_W-1:0] dividend;
  logic             div_busy;
  logic             div_done;
  logic [5:0]       div_rem;

  verdict_t    verdict;
  stat_class_t cls;
  logic [5:0]  target;
  logic [15:0] match_port;
  logic [1:0]  stat_idx;
  logic [31:0] cnt_sel;
  logic [31:0] cnt_inc;
  logic [31:0] stat_count;

  always_comb begin
    if (cpu_count == 8'd0 || cpu_count > {1'b0, MAX_CPU}) begin
      cpu_n = 7'd1;
    end else begin
      cpu_n = cpu_count[6:0];
    end
  end

  // Offsets inside the UDP and application headers depend on the IHL.
  assign off8      = {1'b0, byte_offset};
  assign udp_start = ETH_LEN + {2'b00, ip_words, 2'b00};
  assign ihl_ok    = (ip_words >= MIN_IHL);
  assign in_dport  = ihl_ok && (off8 == udp_start + UDP_DPORT_OFF ||
                                off8 == udp_start + UDP_DPORT_OFF + 8'd1);
  assign in_magic  = ihl_ok && off8 >= udp_start + APP_MAGIC_OFF &&
                     off8 < udp_start + APP_KEY_OFF;

  assign status.key_byte = ihl_ok && off8 >= udp_start + APP_KEY_OFF &&
                           off8 < udp_start + APP_KEY_END;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  assign key_cur  = cmd.key_load ? div_rem : key_remainder;
  assign dividend = cmd.div_from_byte ? {key_remainder, in_byte} : {8'd0, key_cur};

  udp_hcs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (cpu_n),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_port         <= '0;
      cpu_count        <= 8'd1;
      cpu_present_mask <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UDP_PORT:  udp_port         <= cfg_data[15:0];
        CFG_CPU_COUNT: cpu_count        <= cfg_data[7:0];
        CFG_CPU_MASK:  cpu_present_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification of the finished frame; byte_offset equals its length, saturated at 127, here.
  always_comb begin
    match_port = (udp_port != 16'd0) ? udp_port : DEFAULT_UDP_PORT;
    verdict    = VERDICT_PASS;
    cls        = CLS_NONE;
    target     = '0;
    if (off8 < ETH_LEN) begin
      cls = CLS_INVALID;
    end else if (ether_type != ETHERTYPE_IPV4) begin
      cls = CLS_NONE;
    end else if (off8 < IPV4_MIN_END || !ihl_ok) begin
      cls = CLS_INVALID;
    end else if (ip_protocol != IP_PROTO_UDP) begin
      cls = CLS_NONE;
    end else if (off8 < udp_start + UDP_HDR_LEN) begin
      cls = CLS_INVALID;
    end else if (dest_port != match_port) begin
      cls = CLS_NONE;
    end else if (off8 < udp_start + UDP_HDR_LEN + APP_HEADER_BYTES ||
                 magic_word != APP_MAGIC) begin
      verdict = VERDICT_DROP;
      cls     = CLS_DROPPED;
    end else if (cpu_present_mask[div_rem]) begin
      verdict = VERDICT_REDIRECT;
      cls     = CLS_REDIRECT;
      target  = div_rem;
    end else begin
      cls = CLS_PASSED;
    end
  end

  always_comb begin
    case (cls)
      CLS_DROPPED:  stat_idx = 2'd0;
      CLS_PASSED:   stat_idx = 2'd1;
      CLS_REDIRECT: stat_idx = 2'd2;
      CLS_INVALID:  stat_idx = 2'd3;
      default:      stat_idx = 2'd0;
    endcase
    cnt_sel    = stat_cnt[stat_idx];
    cnt_inc    = (cnt_sel == '1) ? cnt_sel : cnt_sel + 32'd1;
    stat_count = (cls == CLS_NONE) ? 32'd0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      ether_type    <= '0;
      ip_words      <= '0;
      ip_protocol   <= '0;
      dest_port     <= '0;
      magic_word    <= '0;
      key_remainder <= '0;
      for (int i = 0; i < 4; i++) begin
        stat_cnt[i] <= '0;
      end
    end else if (cmd.emit) begin
      byte_offset   <= '0;
      ether_type    <= '0;
      ip_words      <= '0;
      ip_protocol   <= '0;
      dest_port     <= '0;
      magic_word    <= '0;
      key_remainder <= '0;
      if (cls != CLS_NONE) begin
        stat_cnt[stat_idx] <= cnt_inc;
      end
    end else begin
      if (cmd.key_load) begin
        key_remainder <= div_rem;
      end
      if (cmd.accept) begin
        if (byte_offset == ETH_TYPE_OFF_HI || byte_offset == ETH_TYPE_OFF_LO) begin
          ether_type <= {ether_type[7:0], in_byte};
        end
        if (byte_offset == IP_IHL_OFF) begin
          ip_words <= in_byte[3:0];
        end
        if (byte_offset == IP_PROTO_OFF) begin
          ip_protocol <= in_byte;
        end
        if (in_dport) begin
          dest_port <= {dest_port[7:0], in_byte};
        end
        if (in_magic) begin
          magic_word <= {magic_word[23:0], in_byte};
        end
        if (byte_offset != OFFSET_MAX) begin
          byte_offset <= byte_offset + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {5'd0, stat_count, cls, target, verdict};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/udp_hcs_ctrl.sv
// Controller: sequences byte intake, remainder steps and result emission.
`timescale 1ns / 1ps
`default_nettype none

module udp_hcs_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_last,
  output logic                          in_ready,
  input  wire udp_hcs_pkg::dp_status_t  status,
  output udp_hcs_pkg::ctrl_cmd_t        cmd
);
  import udp_hcs_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        frame_last;
  logic        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      frame_last <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        frame_last <= in_last;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.key_byte) begin
            state_next = ST_KEY_DIV;
          end else if (in_last) begin
            state_next = ST_END_DIV;
          end
        end
      end
      ST_KEY_DIV: begin
        if (status.div_done) begin
          state_next = frame_last ? ST_END_DIV : ST_IDLE;
        end
      end
      ST_END_DIV: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The last key byte's remainder feeds the final reduction directly.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept        = accept;
        cmd.div_start     = accept && (status.key_byte || in_last);
        cmd.div_from_byte = status.key_byte;
      end
      ST_KEY_DIV: begin
        cmd.key_load  = status.div_done;
        cmd.div_start = status.div_done && frame_last;
      end
      ST_END_DIV: ;
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/udp_header_classify_steer.sv
// Top level of the UDP header classifier and CPU steering block.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-----------------------------------------
//   s_axis   | s_axis_tvalid / s_axis_tready  | tdata[7:0] frame byte, tlast frame end
//   m_axis   | m_axis_tvalid / m_axis_tready  | tdata: verdict, steer cpu, class, count
//   cfg      | cfg_valid / cfg_ready          | cfg_index register, cfg_data value
//
// A byte outside the partition key, unless it ends the frame, does not stall intake. Each of the four key bytes
// stalls intake while the remainder unit, which retires one dividend bit a cycle, reduces it.
// The last byte is followed by the final reduction and the result write.
// Reset is synchronous and restores configuration, frame state and counters at once.
// A waiting result does not stop intake; only a frame end waits for the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "udp_header_classify_steer_assert.svh"

module udp_header_classify_steer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] verdict, [7:2] steer_cpu, [10:8] stat_class, [42:11] stat_count
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import udp_hcs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  udp_hcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  udp_hcs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  `UHCS_ASSERT_NEXT(a_emit_shows_result, clk, rst, cmd.emit, m_axis_tvalid)
  `UHCS_ASSERT_IMPLY(a_emit_slot_free, clk, rst, cmd.emit, status.out_free)
  `UHCS_ASSERT_IMPLY(a_no_intake_while_dividing, clk, rst, status.div_busy, !s_axis_tready)
  `UHCS_ASSERT_IMPLY(a_redirect_class, clk, rst,
    m_axis_tvalid && m_axis_tdata[1:0] == VERDICT_REDIRECT,
    m_axis_tdata[10:8] == CLS_REDIRECT)

endmodule

`default_nettype wire
